// ----- rtl/gbn_pkg.sv -----
// Shared constants, codes, command type and window helper for the Go-Back-N sender.
`default_nettype none

package gbn_pkg;

	// Sequence space and window
	localparam int SEQ_W            = 3;
	localparam int SEQ_COUNT        = 1 << SEQ_W;
	localparam int WINDOW           = 4;
	localparam int RESULT_LIMIT     = 4;
	localparam int CNT_W            = $clog2(RESULT_LIMIT + 1);
	localparam int PAYLOAD_BITS_DEF = 64;
	localparam int QUEUE_DEPTH      = 2;

	// Input modes
	localparam logic [1:0] MODE_SEND    = 2'd0;
	localparam logic [1:0] MODE_ACK     = 2'd1;
	localparam logic [1:0] MODE_TIMEOUT = 2'd2;

	// Timer actions
	localparam logic [1:0] TIMER_NONE    = 2'd0;
	localparam logic [1:0] TIMER_STOP    = 2'd1;
	localparam logic [1:0] TIMER_RESTART = 2'd2;

	// Command handed from the front part to the back part
	typedef struct packed {
		logic             retx;      // retransmit burst rather than a single result
		logic             accepted;
		logic             pkt_valid;
		logic [SEQ_W-1:0] seq;       // packet sequence, or first sequence of a burst
		logic [1:0]       timer;
		logic             full;      // window state after the item
		logic [CNT_W-1:0] count;     // packets in a burst
	} gbn_cmd_t;

	// Window is full when outstanding reaches the window or the free sequence limit
	function automatic logic window_is_full(input logic [SEQ_W-1:0] base,
			input logic [SEQ_W-1:0] next);
		logic [SEQ_W-1:0] n;
		n = next - base;
		return (int'(n) >= WINDOW) || (int'(n) >= SEQ_COUNT - 1);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gbn_front.sv -----
// Front part: accepts input items, updates the window pointers and issues commands.
`default_nettype none

module gbn_front #(
	parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [1:0]                     mode,
	input  wire logic [PAYLOAD_BITS-1:0]        message_data,
	input  wire logic [gbn_pkg::SEQ_W-1:0]      ack_number,
	input  wire logic                           ack_checksum_ok,
	input  wire logic                           q_full,
	output logic                                busy,
	output logic                                push,
	output gbn_pkg::gbn_cmd_t                   cmd,
	output logic [PAYLOAD_BITS-1:0]             cmd_data
);

	logic [gbn_pkg::SEQ_W-1:0] base_q, next_q;
	logic [gbn_pkg::SEQ_W-1:0] base_d, next_d;
	logic [gbn_pkg::SEQ_W-1:0] outstanding, ack_base;
	logic                      full_now;

	assign busy        = q_full;
	assign push        = start && !q_full;
	assign outstanding = next_q - base_q;
	assign ack_base    = ack_number + gbn_pkg::SEQ_W'(1);
	assign full_now    = gbn_pkg::window_is_full(base_q, next_q);

	// Classify the item and build its command
	always_comb begin
		base_d        = base_q;
		next_d        = next_q;
		cmd           = '0;
		cmd.full      = full_now;
		cmd_data      = '0;
		unique case (mode)
			gbn_pkg::MODE_SEND: begin
				if (!full_now) begin
					cmd.accepted  = 1'b1;
					cmd.pkt_valid = 1'b1;
					cmd.seq       = next_q;
					cmd.timer     = (base_q == next_q) ? gbn_pkg::TIMER_RESTART
						: gbn_pkg::TIMER_NONE;
					cmd_data      = message_data;
					next_d        = next_q + gbn_pkg::SEQ_W'(1);
					cmd.full      = gbn_pkg::window_is_full(base_q, next_d);
				end
			end
			gbn_pkg::MODE_ACK: begin
				if (ack_checksum_ok) begin
					base_d    = ack_base;
					cmd.timer = (ack_base == next_q) ? gbn_pkg::TIMER_STOP
						: gbn_pkg::TIMER_RESTART;
					cmd.full  = gbn_pkg::window_is_full(ack_base, next_q);
				end
			end
			gbn_pkg::MODE_TIMEOUT: begin
				if (outstanding == '0) begin
					cmd.timer = gbn_pkg::TIMER_RESTART;
				end else begin
					cmd.retx  = 1'b1;
					cmd.seq   = base_q;
					cmd.count = (int'(outstanding) > gbn_pkg::RESULT_LIMIT)
						? gbn_pkg::CNT_W'(gbn_pkg::RESULT_LIMIT)
						: gbn_pkg::CNT_W'(outstanding);
				end
			end
			default: begin
			end
		endcase
	end

	// Advance the window pointers on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			next_q <= '0;
		end else if (push) begin
			base_q <= base_d;
			next_q <= next_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gbn_queue.sv -----
// Short command queue between the front and back parts.
`default_nettype none

module gbn_queue #(
	parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire gbn_pkg::gbn_cmd_t       push_cmd,
	input  wire logic [PAYLOAD_BITS-1:0] push_data,
	input  wire logic                    pop,
	output gbn_pkg::gbn_cmd_t            head_cmd,
	output logic [PAYLOAD_BITS-1:0]      head_data,
	output logic                         empty,
	output logic                         full
);

	localparam int PTR_W = (gbn_pkg::QUEUE_DEPTH > 1) ? $clog2(gbn_pkg::QUEUE_DEPTH) : 1;
	localparam int LVL_W = $clog2(gbn_pkg::QUEUE_DEPTH + 1);

	gbn_pkg::gbn_cmd_t         cmd_mem_q  [gbn_pkg::QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]   data_mem_q [gbn_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]          wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0]          level_q;

	assign empty     = (level_q == '0);
	assign full      = (level_q == LVL_W'(gbn_pkg::QUEUE_DEPTH));
	assign head_cmd  = cmd_mem_q[rd_ptr_q];
	assign head_data = data_mem_q[rd_ptr_q];

	// Step a pointer with wrap at the queue depth
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (int'(p) == gbn_pkg::QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
	endfunction

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wr_ptr_q]  <= push_cmd;
			data_mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gbn_back.sv -----
// Back part: payload store, retransmit sequencer and registered result outputs.
`default_nettype none

module gbn_back #(
	parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_empty,
	input  wire gbn_pkg::gbn_cmd_t            head_cmd,
	input  wire logic [PAYLOAD_BITS-1:0]      head_data,
	output logic                              pop,
	output logic                              result_strobe,
	output logic                              accepted,
	output logic                              packet_valid,
	output logic [gbn_pkg::SEQ_W-1:0]         packet_seq,
	output logic [PAYLOAD_BITS-1:0]           packet_data,
	output logic [1:0]                        timer_action,
	output logic                              window_full,
	output logic                              last
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RETX = 2'b10
	} state_t;

	state_t                       state_q;
	logic [PAYLOAD_BITS-1:0]      store_q [gbn_pkg::SEQ_COUNT];
	logic [gbn_pkg::SEQ_W-1:0]    seq_q;
	logic [gbn_pkg::CNT_W-1:0]    left_q;
	logic                         first_q, full_hold_q;
	logic                         strobe_q, acc_q, valid_q, full_q, last_q;
	logic [gbn_pkg::SEQ_W-1:0]    pseq_q;
	logic [PAYLOAD_BITS-1:0]      pdata_q;
	logic [1:0]                   timer_q;
	logic                         in_retx;

	assign in_retx = (state_q == ST_RETX);
	assign pop     = (state_q == ST_IDLE) && !q_empty;

	assign result_strobe = strobe_q;
	assign accepted      = acc_q;
	assign packet_valid  = valid_q;
	assign packet_seq    = pseq_q;
	assign packet_data   = pdata_q;
	assign timer_action  = timer_q;
	assign window_full   = full_q;
	assign last          = last_q;

	// Write new payloads in command order
	always_ff @(posedge clk) begin
		if (pop && !head_cmd.retx && head_cmd.pkt_valid) begin
			store_q[head_cmd.seq] <= head_data;
		end
	end

	// Sequence the back part and raise the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (pop && !head_cmd.retx) || in_retx;
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head_cmd.retx) begin
						state_q <= ST_RETX;
					end
				end
				ST_RETX: begin
					if (left_q == gbn_pkg::CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load single results or step through a retransmit burst
	always_ff @(posedge clk) begin
		if (pop) begin
			seq_q       <= head_cmd.seq;
			left_q      <= head_cmd.count;
			first_q     <= 1'b1;
			full_hold_q <= head_cmd.full;
			if (!head_cmd.retx) begin
				acc_q   <= head_cmd.accepted;
				valid_q <= head_cmd.pkt_valid;
				pseq_q  <= head_cmd.seq;
				pdata_q <= head_data;
				timer_q <= head_cmd.timer;
				full_q  <= head_cmd.full;
				last_q  <= 1'b1;
			end
		end else if (in_retx) begin
			acc_q   <= 1'b0;
			valid_q <= 1'b1;
			pseq_q  <= seq_q;
			pdata_q <= store_q[seq_q];
			timer_q <= first_q ? gbn_pkg::TIMER_RESTART : gbn_pkg::TIMER_NONE;
			full_q  <= full_hold_q;
			last_q  <= (left_q == gbn_pkg::CNT_W'(1));
			seq_q   <= seq_q + gbn_pkg::SEQ_W'(1);
			left_q  <= left_q - gbn_pkg::CNT_W'(1);
			first_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/go_back_n_sender_window_top.sv -----
// Top level of the Go-Back-N sender window: front part, command queue and back part.
`default_nettype none

// An item is taken on a clock edge with start high and busy low; busy is high only while
// the two-entry command queue is full. The front part handles every item in the cycle it
// is taken, so items can follow one another back to back. Send, acknowledgment and unknown
// items each give one result; a timeout gives one result per outstanding packet, at most
// four, one per cycle as the back part reads the payload store, or one result if none is
// outstanding. The back part emits at most one result per cycle, so a timeout burst
// occupies it while it takes the command and then emits one result per packet, and the
// queue fills behind it. A result passes through the command queue and then the back
// part's output registers, and is shown for exactly one cycle with result_strobe high;
// the receiver cannot stall, so it must take every result as it appears. Results come
// in the order of the items, and last marks the final result of each item.
module go_back_n_sender_window_top #(
	parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                mode,
	input  wire logic [PAYLOAD_BITS-1:0]   message_data,
	input  wire logic [2:0]                ack_number,
	input  wire logic                      ack_checksum_ok,
	output logic                           result_strobe,
	output logic                           accepted,
	output logic                           packet_valid,
	output logic [2:0]                     packet_seq,
	output logic [PAYLOAD_BITS-1:0]        packet_data,
	output logic [1:0]                     timer_action,
	output logic                           window_full,
	output logic                           last
);

	gbn_pkg::gbn_cmd_t          push_cmd, head_cmd;
	logic [PAYLOAD_BITS-1:0]    push_data, head_data;
	logic                       push, pop, q_empty, q_full;

	gbn_front #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.mode            (mode),
		.message_data    (message_data),
		.ack_number      (ack_number),
		.ack_checksum_ok (ack_checksum_ok),
		.q_full          (q_full),
		.busy            (busy),
		.push            (push),
		.cmd             (push_cmd),
		.cmd_data        (push_data)
	);

	gbn_queue #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_data (push_data),
		.pop       (pop),
		.head_cmd  (head_cmd),
		.head_data (head_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	gbn_back #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head_cmd      (head_cmd),
		.head_data     (head_data),
		.pop           (pop),
		.result_strobe (result_strobe),
		.accepted      (accepted),
		.packet_valid  (packet_valid),
		.packet_seq    (packet_seq),
		.packet_data   (packet_data),
		.timer_action  (timer_action),
		.window_full   (window_full),
		.last          (last)
	);

endmodule

`default_nettype wire

// ----- test/go_back_n_sender_window_top_test.sv -----
// Self-checking testbench for the Go-Back-N sender window: directed and random transfers.
`default_nettype none

module go_back_n_sender_window_top_test;
	import gbn_pkg::*;

	localparam logic [1:0] MODE_UNKNOWN = 2'd3;
	localparam int DATA_W = 64;

	// One result as the block presents it
	typedef struct {
		logic              acc;
		logic              valid;
		logic [SEQ_W-1:0]  seq;
		logic [DATA_W-1:0] data;
		logic [1:0]        timer;
		logic              full;
		logic              last;
	} window_result_t;

	// Sender window state, expected results and run statistics
	class window_scoreboard;
		logic [SEQ_W-1:0]  base;
		logic [SEQ_W-1:0]  next_seq;
		logic [DATA_W-1:0] payloads[SEQ_COUNT];
		bit                written[SEQ_COUNT];
		window_result_t    pending_results[$];
		int                errors;
		int                items;
		int                refused;
		int                timeouts;
		int                checked;
		int                resent;

		function new();
			base = '0;
			next_seq = '0;
			foreach (payloads[i]) begin
				payloads[i] = '0;
				written[i] = 1'b0;
			end
		endfunction

		function logic [SEQ_W-1:0] in_flight();
			return next_seq - base;
		endfunction

		function logic window_closed();
			return (int'(in_flight()) >= WINDOW) || (int'(in_flight()) >= SEQ_COUNT - 1);
		endfunction

		// A timeout only reads store entries that have been written
		function bit retransmit_safe();
			int cnt;
			cnt = int'(in_flight());
			if (cnt > RESULT_LIMIT)
				cnt = RESULT_LIMIT;
			for (int i = 0; i < cnt; i++) begin
				if (!written[3'(base + 3'(i))])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void push(logic acc, logic valid, logic [SEQ_W-1:0] seq,
				logic [DATA_W-1:0] data, logic [1:0] timer, logic last);
			window_result_t r;
			r.acc = acc;
			r.valid = valid;
			r.seq = seq;
			r.data = data;
			r.timer = timer;
			r.full = window_closed();
			r.last = last;
			pending_results.push_back(r);
		endfunction

		// Advance the window for one transfer and queue the results it causes
		function void note_item(logic [1:0] m, logic [DATA_W-1:0] d, logic [SEQ_W-1:0] a,
				logic ok);
			int cnt;
			logic [SEQ_W-1:0] seq;
			logic [1:0] timer;
			items++;
			case (m)
				MODE_SEND: begin
					if (window_closed()) begin
						refused++;
						push(1'b0, 1'b0, '0, '0, TIMER_NONE, 1'b1);
					end else begin
						seq = next_seq;
						timer = (base == next_seq) ? TIMER_RESTART : TIMER_NONE;
						payloads[seq] = d;
						written[seq] = 1'b1;
						next_seq = seq + 3'd1;
						push(1'b1, 1'b1, seq, d, timer, 1'b1);
					end
				end
				MODE_ACK: begin
					if (!ok) begin
						push(1'b0, 1'b0, '0, '0, TIMER_NONE, 1'b1);
					end else begin
						base = a + 3'd1;
						push(1'b0, 1'b0, '0, '0,
							(base == next_seq) ? TIMER_STOP : TIMER_RESTART, 1'b1);
					end
				end
				MODE_TIMEOUT: begin
					timeouts++;
					cnt = int'(in_flight());
					if (cnt == 0) begin
						push(1'b0, 1'b0, '0, '0, TIMER_RESTART, 1'b1);
					end else begin
						if (cnt > RESULT_LIMIT)
							cnt = RESULT_LIMIT;
						for (int i = 0; i < cnt; i++) begin
							seq = base + 3'(i);
							push(1'b0, 1'b1, seq, payloads[seq],
								(i == 0) ? TIMER_RESTART : TIMER_NONE, i == cnt - 1);
						end
					end
				end
				default: begin
					push(1'b0, 1'b0, '0, '0, TIMER_NONE, 1'b1);
				end
			endcase
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] want,
				logic [DATA_W-1:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		// Compare one result with the oldest expectation
		function void check_result(window_result_t got);
			window_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$error("result with no expectation pending");
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (want.valid && !want.acc)
				resent++;
			compare_field("accepted", want.acc, got.acc);
			compare_field("packet_valid", want.valid, got.valid);
			compare_field("packet_seq", want.seq, got.seq);
			compare_field("packet_data", want.data, got.data);
			compare_field("timer_action", want.timer, got.timer);
			compare_field("window_full", want.full, got.full);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        mode = MODE_SEND;
	logic [DATA_W-1:0] message_data = '0;
	logic [2:0]        ack_number = '0;
	logic              ack_checksum_ok = 1'b0;
	logic              busy;
	logic              result_strobe;
	logic              accepted;
	logic              packet_valid;
	logic [2:0]        packet_seq;
	logic [DATA_W-1:0] packet_data;
	logic [1:0]        timer_action;
	logic              window_full;
	logic              last;

	window_scoreboard sb = new();
	int idle_pct = 24;

	go_back_n_sender_window_top #(.PAYLOAD_BITS(DATA_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.message_data(message_data),
		.ack_number(ack_number),
		.ack_checksum_ok(ack_checksum_ok),
		.result_strobe(result_strobe),
		.accepted(accepted),
		.packet_valid(packet_valid),
		.packet_seq(packet_seq),
		.packet_data(packet_data),
		.timer_action(timer_action),
		.window_full(window_full),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Bound the run in case the block hangs
	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	// Take each result mid-cycle, well away from the clock edge
	always @(negedge clk) begin
		window_result_t got;
		if (arst_n && result_strobe) begin
			got.acc = accepted;
			got.valid = packet_valid;
			got.seq = packet_seq;
			got.data = packet_data;
			got.timer = timer_action;
			got.full = window_full;
			got.last = last;
			sb.check_result(got);
		end
	end

	// Present one item, hold it until busy lets it through, then note the transfer
	task automatic drive_item(input logic [1:0] m, input logic [DATA_W-1:0] d,
			input logic [2:0] a, input logic ok);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		message_data <= d;
		ack_number <= a;
		ack_checksum_ok <= ok;
		@(negedge clk);
		while (busy) begin
			@(posedge clk);
			@(negedge clk);
		end
		sb.note_item(m, d, a, ok);
		@(posedge clk);
	endtask

	// Mostly well-formed traffic: sends, in-window acks and safe timeouts, plus some noise
	task automatic random_item();
		int pick;
		logic [1:0] m;
		logic [DATA_W-1:0] d;
		logic [2:0] a;
		logic ok;
		pick = $urandom_range(99);
		d = {$urandom, $urandom};
		case ($urandom_range(7))
			0: d = '0;
			1: d = '1;
			default: ;
		endcase
		a = 3'($urandom_range(7));
		ok = 1'($urandom_range(1));
		m = MODE_SEND;
		if (pick < 45) begin
			m = MODE_SEND;
		end else if (pick < 65) begin
			m = MODE_ACK;
			ok = 1'b1;
			a = sb.base + 3'($urandom_range(int'(sb.in_flight()))) - 3'd1;
		end else if (pick < 78) begin
			m = sb.retransmit_safe() ? MODE_TIMEOUT : MODE_SEND;
		end else if (pick < 86) begin
			m = MODE_ACK;
			ok = 1'b0;
		end else if (pick < 94) begin
			m = MODE_ACK;
			ok = 1'b1;
		end else begin
			m = MODE_UNKNOWN;
		end
		drive_item(m, d, a, ok);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the window, refuse, retransmit the full window
		drive_item(MODE_SEND, 64'h0, 3'd0, 1'b0);
		drive_item(MODE_SEND, '1, 3'd7, 1'b1);
		drive_item(MODE_SEND, 64'hA5A5_5A5A_F00F_0FF0, 3'd2, 1'b0);
		drive_item(MODE_SEND, 64'h8000_0000_0000_0001, 3'd5, 1'b1);
		drive_item(MODE_SEND, 64'h1234_5678_9ABC_DEF0, 3'd0, 1'b1);
		drive_item(MODE_TIMEOUT, 64'h0, 3'd0, 1'b0);
		// Bad checksum and unknown mode leave the window alone
		drive_item(MODE_ACK, '1, 3'd7, 1'b0);
		drive_item(MODE_UNKNOWN, '1, 3'd7, 1'b1);
		// Partial ack, short retransmission, ack everything, then a timeout with none outstanding
		drive_item(MODE_ACK, 64'h0, 3'd1, 1'b1);
		drive_item(MODE_TIMEOUT, 64'h0, 3'd0, 1'b0);
		drive_item(MODE_ACK, 64'h0, 3'd3, 1'b1);
		drive_item(MODE_TIMEOUT, 64'h0, 3'd0, 1'b0);
		// Write the upper half of the store, wrapping the sequence number
		drive_item(MODE_SEND, 64'hFFFF_0000_FFFF_0000, 3'd0, 1'b0);
		drive_item(MODE_SEND, 64'h0000_FFFF_0000_FFFF, 3'd0, 1'b0);
		drive_item(MODE_SEND, 64'h7FFF_FFFF_FFFF_FFFE, 3'd0, 1'b0);
		drive_item(MODE_SEND, 64'hDEAD_BEEF_CAFE_F00D, 3'd0, 1'b0);
		// Ack beyond the sent range leaves seven outstanding: full, burst capped at four
		drive_item(MODE_ACK, 64'h0, 3'd0, 1'b1);
		drive_item(MODE_TIMEOUT, 64'h0, 3'd0, 1'b0);
		drive_item(MODE_SEND, 64'h1, 3'd0, 1'b0);
		drive_item(MODE_ACK, 64'h0, 3'd7, 1'b1);
		drive_item(MODE_TIMEOUT, 64'h0, 3'd0, 1'b0);
		drive_item(MODE_SEND, '1, 3'd0, 1'b0);

		// Random traffic under three idling profiles
		for (int i = 0; i < 160; i++)
			random_item();
		idle_pct = 63;
		for (int i = 0; i < 160; i++)
			random_item();
		idle_pct = 0;
		for (int i = 0; i < 160; i++)
			random_item();
		start <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);

		$display("Covered %0d transfers: %0d refused sends, %0d timeouts.",
			sb.items, sb.refused, sb.timeouts);
		$display("Checked %0d results, %0d of them retransmitted packets.",
			sb.checked, sb.resent);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
